// File: hw/rtl/lrs_pkg.sv
// lrs_pkg: shared widths, operation codes and sigmoid table builder
// for the logistic regression scorer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

  // default weight store capacity (bias excluded)
  localparam int LRS_MAX_FEATURES = 256;

  // field widths
  localparam int LRS_INDEX_W     = 9;
  localparam int LRS_VALUE_W     = 16;
  localparam int LRS_PROB_W      = 16;
  localparam int LRS_PROD_W      = 32;
  localparam int LRS_SUM_W       = 40;
  localparam int LRS_IN_TDATA_W  = 32;
  localparam int LRS_OUT_TDATA_W = 24;

  // sigmoid table geometry
  localparam int LRS_ROM_DEPTH = 1024;
  localparam int LRS_ROM_AW    = 10;

  // beat kinds on the input channel
  typedef enum logic {
    LRS_OP_LOAD    = 1'b0,
    LRS_OP_FEATURE = 1'b1
  } lrs_op_t;

  typedef logic [LRS_ROM_DEPTH-1:0][LRS_PROB_W-1:0] lrs_rom_t;

  // shift-subtract divide, used only while building the table
  function automatic logic [63:0] lrs_udiv64(input logic [63:0] num,
                                             input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // (a*b) >> 62 in Q2.62
  function automatic logic [63:0] lrs_mul_q62(input logic [63:0] a,
                                              input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // entry i = round(65535*sigmoid(-8+(i+0.5)/64)) from exp(-k/128), k odd
  function automatic lrs_rom_t lrs_sigmoid_table();
    lrs_rom_t    tbl;
    logic [63:0] term;
    logic [63:0] d;
    logic [63:0] d2;
    logic [63:0] q;
    logic [63:0] qq;
    logic [63:0] den;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << 62;
    d    = 64'd1 << 62;
    // series for exp(-1/128)
    for (int n = 1; n <= 10; n++) begin
      term = lrs_udiv64(term, 64'(128 * n));
      if ((n % 2) == 1) begin
        d = d - term;
      end else begin
        d = d + term;
      end
    end
    d2 = lrs_mul_q62(d, d);
    q  = d;
    for (int k = 1; k <= 1023; k += 2) begin
      qq  = (q + (64'd1 << 21)) >> 22;
      den = (64'd1 << 40) + qq;
      pos = lrs_udiv64((64'd131070 << 40) + den, den << 1);
      neg = lrs_udiv64(64'd131070 * qq + den, den << 1);
      tbl[(k + 1023) >> 1] = pos[LRS_PROB_W-1:0];
      tbl[(1023 - k) >> 1] = neg[LRS_PROB_W-1:0];
      q = lrs_mul_q62(q, d2);
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lrs_ram.sv
// lrs_ram: generic single write port, single read port RAM, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 257
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]         wr_data,
  input  wire                      rd_en,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/lrs_sigmoid_rom.sv
// lrs_sigmoid_rom: 1024-entry Q0.16 sigmoid table with registered read
// depends on lrs_pkg for the table builder
`timescale 1ns / 1ps
`default_nettype none

module lrs_sigmoid_rom
  import lrs_pkg::*;
(
  input  wire                     clk,
  input  wire                     rd_en,
  input  wire  [LRS_ROM_AW-1:0]   rd_addr,
  output logic [LRS_PROB_W-1:0]   rd_data
);

  localparam lrs_rom_t ROM_TABLE = lrs_sigmoid_table();

  logic [LRS_PROB_W-1:0] rd_data_r;

  // table lookup
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM_TABLE[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/logistic_regression_scorer_unit.sv
// logistic_regression_scorer_unit: top level of the logistic regression scorer
// depends on lrs_pkg, lrs_ram and lrs_sigmoid_rom
//
// Usage:
//   in_*  channel: each beat is either a weight load (in_tuser = load) that
//         writes slot weight_index (0 is the bias), or a feature of the
//         current vector (in_tuser = feature); in_tlast marks the last feature.
//   out_* channel: one beat per vector, sent after its last feature: sigmoid
//         probability, predicted class and the too-many-features flag.
//   cfg_*: decision threshold, written while the block is idle.
// Throughput: one beat per cycle, loads and features alike, while in_tready is high;
//   the accumulator takes one multiply-accumulate per cycle while the pipeline advances.
// Pipeline: after the last feature is accepted, out_tvalid rises once the result
//   has passed multiply, accumulate, clamp, table read and compare; the weight
//   read starts at the accepting edge.
// Reset: threshold returns to 32768, the vector count and overflow flag clear,
//   the output register empties; the weight store keeps no reset value and
//   every slot used must be loaded first.
// Stall: a waiting result sits in the output register while feature and load
//   beats keep flowing; only when another result is on its way does in_tready
//   drop until out_tready takes the waiting one.
`timescale 1ns / 1ps
`default_nettype none

module logistic_regression_scorer_unit
  import lrs_pkg::*;
#(
  parameter int MAX_FEATURES = LRS_MAX_FEATURES
) (
  input  wire                         clk,
  input  wire                         rst_n,
  // input channel
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire  [LRS_IN_TDATA_W-1:0]   in_tdata,   // weight_index[8:0], value[24:9]
  input  wire  [0:0]                  in_tuser,   // operation[0]
  input  wire                         in_tlast,   // last_feature
  // result channel
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [LRS_OUT_TDATA_W-1:0]  out_tdata,  // probability[15:0], predicted_class[16]
  output logic [0:0]                  out_tuser,  // too_many_features[0]
  // configuration
  input  wire                         cfg_wr_en,
  input  wire  [LRS_PROB_W-1:0]       cfg_wr_data
);

  localparam int AW = $clog2(MAX_FEATURES + 1);
  localparam int CW = (AW > LRS_INDEX_W) ? AW : LRS_INDEX_W;

  typedef struct packed {
    logic last;
    logic ovf;
  } lrs_tag_t;

  // input beat fields
  lrs_op_t                         in_op;
  logic [LRS_INDEX_W-1:0]          in_index;
  logic signed [LRS_VALUE_W-1:0]   in_value;
  logic [CW-1:0]                   in_index_w;
  logic                            in_acc;
  logic                            feat_acc;
  logic                            load_acc;
  logic                            index_ok;

  // vector tracking
  logic [AW-1:0]                   pos_r, pos_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            pos_full;
  logic [LRS_VALUE_W-1:0]          bias_r;
  logic [LRS_PROB_W-1:0]           thr_r;

  // pipeline
  logic                            en;
  logic                            blocked;
  logic [LRS_VALUE_W-1:0]          weight_rd;
  logic                            s1_valid_r, s1_first_r, s1_add_r;
  lrs_tag_t                        s1_tag_r;
  logic signed [LRS_VALUE_W-1:0]   s1_value_r;
  logic [LRS_VALUE_W-1:0]          s1_bias_r;
  logic                            s2_valid_r, s2_first_r, s2_add_r;
  lrs_tag_t                        s2_tag_r;
  logic signed [LRS_PROD_W-1:0]    s2_prod_r;
  logic [LRS_VALUE_W-1:0]          s2_bias_r;
  logic [LRS_SUM_W-1:0]            acc_r, acc_nxt, acc_base, acc_add;
  logic                            s3_valid_r, s3_ovf_r;
  logic                            s4_valid_r, s4_ovf_r;
  logic [LRS_ROM_AW-1:0]           s4_idx_r, idx_nxt;
  logic                            in_range;
  logic                            s5_valid_r, s5_ovf_r;
  logic [LRS_PROB_W-1:0]           prob_rd;

  // output register
  logic                            out_valid_r;
  logic [LRS_PROB_W-1:0]           out_prob_r;
  logic                            out_class_r;
  logic                            out_ovf_r;

  // unpack the input beat
  assign in_op      = lrs_op_t'(in_tuser[0]);
  assign in_index   = in_tdata[LRS_INDEX_W-1:0];
  assign in_value   = in_tdata[LRS_INDEX_W+LRS_VALUE_W-1:LRS_INDEX_W];
  assign in_index_w = CW'(in_index);
  assign index_ok   = (in_index_w <= CW'(MAX_FEATURES));

  // stall only when a result would land on a held output beat
  assign blocked = out_valid_r && !out_tready &&
                   ((s1_valid_r && s1_tag_r.last) || (s2_valid_r && s2_tag_r.last) ||
                    s3_valid_r || s4_valid_r || s5_valid_r);
  assign en        = !blocked;
  assign in_tready = en;
  assign in_acc    = in_tvalid && in_tready;
  assign feat_acc  = in_acc && (in_op == LRS_OP_FEATURE);
  assign load_acc  = in_acc && (in_op == LRS_OP_LOAD);

  // feature count and overflow of the current vector
  assign pos_full = (pos_r == AW'(MAX_FEATURES));

  always_comb begin
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    if (feat_acc) begin
      if (in_tlast) begin
        pos_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (!pos_full) begin
        pos_nxt = pos_r + AW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ovf_r <= 1'b0;
      thr_r <= LRS_PROB_W'(32768);
    end else begin
      pos_r <= pos_nxt;
      ovf_r <= ovf_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  // bias shadow so the first feature needs only one store read
  always_ff @(posedge clk) begin
    if (load_acc && (in_index_w == '0)) begin
      bias_r <= in_value;
    end
  end

  // weight store
  lrs_ram #(
    .WIDTH (LRS_VALUE_W),
    .DEPTH (MAX_FEATURES + 1)
  ) u_weights (
    .clk     (clk),
    .wr_en   (load_acc && index_ok),
    .wr_addr (in_index_w[AW-1:0]),
    .wr_data (in_value),
    .rd_en   (feat_acc),
    .rd_addr (pos_r + AW'(1)),
    .rd_data (weight_rd)
  );

  // stage 1: feature beat, weight read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= feat_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (feat_acc) begin
      s1_first_r    <= (pos_r == '0);
      s1_add_r      <= !pos_full;
      s1_tag_r.last <= in_tlast;
      s1_tag_r.ovf  <= ovf_r || pos_full;
      s1_value_r    <= in_value;
      s1_bias_r     <= bias_r;
    end
  end

  // stage 2: Q4.12 x Q4.12 product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_first_r <= s1_first_r;
      s2_add_r   <= s1_add_r;
      s2_tag_r   <= s1_tag_r;
      s2_bias_r  <= s1_bias_r;
      s2_prod_r  <= LRS_PROD_W'(s1_value_r) * LRS_PROD_W'($signed(weight_rd));
    end
  end

  // stage 3: accumulate, bias scaled to Q16.24 on the first feature
  assign acc_base = s2_first_r ?
                    {{(LRS_SUM_W-LRS_VALUE_W-12){s2_bias_r[LRS_VALUE_W-1]}}, s2_bias_r, 12'd0} :
                    acc_r;
  assign acc_add  = s2_add_r ?
                    {{(LRS_SUM_W-LRS_PROD_W){s2_prod_r[LRS_PROD_W-1]}}, s2_prod_r} :
                    '0;
  assign acc_nxt  = acc_base + acc_add;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r && s2_tag_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid_r) begin
      acc_r    <= acc_nxt;
      s3_ovf_r <= s2_tag_r.ovf;
    end
  end

  // stage 4: clamp to [-8,8) and form the table index
  assign in_range = (&acc_r[LRS_SUM_W-1:27]) || !(|acc_r[LRS_SUM_W-1:27]);

  always_comb begin
    if (in_range) begin
      idx_nxt = {~acc_r[27], acc_r[26:18]};
    end else if (acc_r[LRS_SUM_W-1]) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_idx_r <= idx_nxt;
      s4_ovf_r <= s3_ovf_r;
    end
  end

  // stage 5: sigmoid table read
  lrs_sigmoid_rom u_sigmoid (
    .clk     (clk),
    .rd_en   (en),
    .rd_addr (s4_idx_r),
    .rd_data (prob_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ovf_r <= s4_ovf_r;
    end
  end

  // output register with threshold compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && s5_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s5_valid_r) begin
      out_prob_r  <= prob_rd;
      out_class_r <= (prob_rd > thr_r);
      out_ovf_r   <= s5_ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(LRS_OUT_TDATA_W-LRS_PROB_W-1){1'b0}}, out_class_r, out_prob_r};
  assign out_tuser  = out_ovf_r;

`ifndef NO_ASSERTIONS
  // last feature closes the vector
  a_vector_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (feat_acc && in_tlast) |=> (pos_r == '0) && !ovf_r)
    else $error("vector state not cleared after last feature");

  // overflow only once the count has saturated
  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> pos_full)
    else $error("overflow flag set below capacity");

  // count never passes capacity
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= AW'(MAX_FEATURES))
    else $error("feature count beyond capacity");

  // a result ready to leave never overwrites a held output beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && s5_valid_r) |-> !in_tready)
    else $error("pipeline advanced into a held output beat");
`endif

endmodule

`default_nettype wire

// File: verif/lrs_score_checker.sv
// lrs_score_checker: watches the input, result and threshold ports of the scorer,
// predicts every score beat and compares it field by field with what comes out
// depends on lrs_pkg for widths, the weight store size and the beat kinds
`timescale 1ns / 1ps

module lrs_score_checker
  import lrs_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [LRS_IN_TDATA_W-1:0]  in_tdata,   // weight_index[8:0], value[24:9]
  input  logic [0:0]                 in_tuser,   // operation[0]
  input  logic                       in_tlast,   // last_feature
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [LRS_OUT_TDATA_W-1:0] out_tdata,  // probability[15:0], predicted_class[16]
  input  logic [0:0]                 out_tuser,  // too_many_features[0]
  input  logic                       cfg_wr_en,
  input  logic [LRS_PROB_W-1:0]      cfg_wr_data,
  output int                         error_count,
  output int                         results_pending
);

  // clamp window of the running sum, [-8, 8) in Q16.24
  localparam logic signed [LRS_SUM_W-1:0] SUM_FLOOR = -40'sd134217728;
  localparam logic signed [LRS_SUM_W-1:0] SUM_CEIL  = 40'sd134217727;

  typedef struct packed {
    logic [LRS_PROB_W-1:0] probability;
    logic                  predicted_class;
    logic                  too_many_features;
  } score_t;

  logic [LRS_PROB_W-1:0]         sigmoid_lut [0:LRS_ROM_DEPTH-1];
  logic signed [LRS_VALUE_W-1:0] weights [0:LRS_MAX_FEATURES];
  logic signed [LRS_SUM_W-1:0]   accum;
  int                            feat_count;
  logic                          saw_excess;
  logic [LRS_PROB_W-1:0]         threshold;
  score_t                        expected_scores [$];

  // sigmoid table from a series for exp(-1/128) raised to odd powers
  function automatic void build_sigmoid_lut();
    logic [63:0]  term;
    logic [63:0]  base;
    logic [63:0]  base_sq;
    logic [63:0]  q;
    logic [63:0]  qq;
    logic [63:0]  den;
    logic [63:0]  upper;
    logic [63:0]  lower;
    logic [127:0] wide;
    term = 64'd1 << 62;
    base = 64'd1 << 62;
    for (int n = 1; n <= 10; n++) begin
      term = term / (64'd128 * n);
      if (n % 2 == 1) begin
        base = base - term;
      end else begin
        base = base + term;
      end
    end
    wide    = {64'd0, base} * {64'd0, base};
    base_sq = wide[125:62];
    q       = base;
    for (int k = 1; k <= 1023; k += 2) begin
      qq    = (q + (64'd1 << 21)) >> 22;
      den   = (64'd1 << 40) + qq;
      upper = ((64'd131070 << 40) + den) / (den << 1);
      lower = (64'd131070 * qq + den) / (den << 1);
      sigmoid_lut[(k + 1023) / 2] = upper[LRS_PROB_W-1:0];
      sigmoid_lut[(1023 - k) / 2] = lower[LRS_PROB_W-1:0];
      wide = {64'd0, q} * {64'd0, base_sq};
      q    = wide[125:62];
    end
  endfunction

  initial begin
    build_sigmoid_lut();
  end

  // weight load or one multiply-accumulate; a last feature yields a score
  task automatic take_input_beat();
    logic [LRS_INDEX_W-1:0]        slot;
    logic signed [LRS_VALUE_W-1:0] value;
    logic signed [LRS_SUM_W-1:0]   bias_ext;
    logic signed [31:0]            wide_feat;
    logic signed [31:0]            wide_weight;
    logic signed [31:0]            product;
    logic signed [LRS_SUM_W-1:0]   clamped;
    logic [LRS_SUM_W-1:0]          offset;
    score_t                        score;
    slot  = in_tdata[LRS_INDEX_W-1:0];
    value = in_tdata[LRS_INDEX_W +: LRS_VALUE_W];
    if (in_tuser[0] == LRS_OP_LOAD) begin
      if (slot <= LRS_MAX_FEATURES) begin
        weights[slot] = value;
      end
    end else begin
      // bias enters when the vector's first feature arrives
      if (feat_count == 0) begin
        bias_ext = weights[0];
        accum    = bias_ext <<< 12;
      end
      if (feat_count < LRS_MAX_FEATURES) begin
        wide_feat   = value;
        wide_weight = weights[feat_count + 1];
        product     = wide_feat * wide_weight;
        accum       = accum + product;
        feat_count++;
      end else begin
        saw_excess = 1'b1;
      end
      if (in_tlast) begin
        clamped = accum;
        if (clamped < SUM_FLOOR) begin
          clamped = SUM_FLOOR;
        end else if (clamped > SUM_CEIL) begin
          clamped = SUM_CEIL;
        end
        offset                  = clamped - SUM_FLOOR;
        score.probability       = sigmoid_lut[offset[27:18]];
        score.predicted_class   = score.probability > threshold;
        score.too_many_features = saw_excess;
        expected_scores.push_back(score);
        accum      = '0;
        feat_count = 0;
        saw_excess = 1'b0;
      end
    end
  endtask

  // compare a result beat with the oldest predicted score
  task automatic check_result_beat();
    score_t want;
    if (expected_scores.size() == 0) begin
      $error("result beat with no score pending: tdata %h tuser %h", out_tdata, out_tuser);
      error_count++;
    end else begin
      want = expected_scores.pop_front();
      if (out_tdata[LRS_PROB_W-1:0] !== want.probability) begin
        $error("probability: expected %0d, got %0d", want.probability,
               out_tdata[LRS_PROB_W-1:0]);
        error_count++;
      end
      if (out_tdata[LRS_PROB_W] !== want.predicted_class) begin
        $error("predicted_class: expected %0d, got %0d", want.predicted_class,
               out_tdata[LRS_PROB_W]);
        error_count++;
      end
      if (out_tuser[0] !== want.too_many_features) begin
        $error("too_many_features: expected %0d, got %0d", want.too_many_features,
               out_tuser[0]);
        error_count++;
      end
    end
  endtask

  initial begin
    error_count     = 0;
    results_pending = 0;
  end

  // sample every port at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      accum      = '0;
      feat_count = 0;
      saw_excess = 1'b0;
      threshold  = 16'd32768;
      expected_scores.delete();
    end else begin
      if (cfg_wr_en) begin
        threshold = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        take_input_beat();
      end
      if (out_tvalid && out_tready) begin
        check_result_beat();
      end
    end
    results_pending = expected_scores.size();
  end

endmodule

// File: verif/tb_top.sv
// tb_top: stimulus and verdict for logistic_regression_scorer_unit; weight loads,
// directed and random feature vectors under several thresholds, random stalls
// depends on lrs_pkg, the scorer RTL and lrs_score_checker
`timescale 1ns / 1ps

module tb_top;
  import lrs_pkg::*;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [LRS_IN_TDATA_W-1:0]  in_tdata;   // weight_index[8:0], value[24:9]
  logic [0:0]                 in_tuser;   // operation[0]
  logic                       in_tlast;   // last_feature
  logic                       out_tvalid;
  logic                       out_tready = 1'b1;
  logic [LRS_OUT_TDATA_W-1:0] out_tdata;  // probability[15:0], predicted_class[16]
  logic [0:0]                 out_tuser;  // too_many_features[0]
  logic                       cfg_wr_en;
  logic [LRS_PROB_W-1:0]      cfg_wr_data;

  int   error_count;
  int   results_pending;
  int   beats_used;
  logic steady;

  logistic_regression_scorer_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lrs_score_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .error_count     (error_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // result side back-pressure, off during steady stretches
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 7);
  end

  // Q4.12 values: mostly within +-2.0, with extremes and full-range noise
  function automatic logic [LRS_VALUE_W-1:0] rand_q412();
    logic [LRS_VALUE_W-1:0] v;
    case ($urandom_range(0, 15))
      0:       v = 16'($urandom);
      1:       v = 16'h7FFF;
      2:       v = 16'h8000;
      3:       v = 16'h0000;
      default: v = 16'($urandom_range(0, 16383)) - 16'd8192;
    endcase
    return v;
  endfunction

  // one beat on the input channel; entered and left at a falling edge
  task automatic send_beat(input lrs_op_t op, input logic [LRS_INDEX_W-1:0] slot,
                           input logic [LRS_VALUE_W-1:0] value, input logic last);
    while (!steady && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, value, slot};
    in_tlast  <= last;
    do begin
      @(posedge clk);
    end while (!in_tready);
    @(negedge clk);
    if (op == LRS_OP_FEATURE || slot <= LRS_MAX_FEATURES) begin
      beats_used++;
    end
  endtask

  // a vector of features, with weight loads mixed in now and then
  task automatic score_vector(input int n_feat, input int load_pct);
    for (int i = 0; i < n_feat; i++) begin
      if ($urandom_range(0, 99) < load_pct) begin
        send_beat(LRS_OP_LOAD, 9'($urandom_range(0, LRS_MAX_FEATURES)), rand_q412(),
                  1'($urandom));
      end
      send_beat(LRS_OP_FEATURE, 9'($urandom), rand_q412(), i == n_feat - 1);
    end
  endtask

  // threshold write once every score is out and the pipeline has drained
  task automatic set_threshold(input logic [LRS_PROB_W-1:0] thr);
    in_tvalid <= 1'b0;
    while (results_pending != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // random mix: mostly well-formed vectors, some stray and ignored loads
  task automatic random_segment(input int beat_goal);
    int stop_at;
    int pick;
    stop_at = beats_used + beat_goal;
    while (beats_used < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 9) == 0) begin
          score_vector($urandom_range(9, 40), 8);
        end else begin
          score_vector($urandom_range(1, 8), 8);
        end
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(LRS_OP_LOAD, 9'($urandom_range(0, LRS_MAX_FEATURES)), rand_q412(),
                    1'($urandom));
        end
      end else begin
        send_beat(LRS_OP_LOAD, 9'($urandom_range(LRS_MAX_FEATURES + 1, 511)), rand_q412(),
                  1'($urandom));
      end
    end
  endtask

  // run limit
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    in_tlast    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    steady      = 1'b0;
    beats_used  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill the whole weight store first, some loads carrying a last mark
    for (int s = 0; s <= LRS_MAX_FEATURES; s++) begin
      send_beat(LRS_OP_LOAD, 9'(s), rand_q412(), 1'($urandom));
    end

    // directed: zero sum, exact lower bound, both clamps, ignored loads,
    // bias change and weight change inside a vector, at reset threshold
    send_beat(LRS_OP_LOAD, 9'd0, 16'h0000, 1'b0);
    send_beat(LRS_OP_LOAD, 9'd1, 16'h1000, 1'b1);
    send_beat(LRS_OP_FEATURE, 9'd0, 16'h0000, 1'b1);
    send_beat(LRS_OP_LOAD, 9'd0, 16'h8000, 1'b0);
    send_beat(LRS_OP_FEATURE, 9'd0, 16'h0000, 1'b1);
    send_beat(LRS_OP_LOAD, 9'd0, 16'h7FFF, 1'b0);
    send_beat(LRS_OP_LOAD, 9'd1, 16'h7FFF, 1'b0);
    send_beat(LRS_OP_FEATURE, 9'd0, 16'h7FFF, 1'b1);
    send_beat(LRS_OP_FEATURE, 9'd0, 16'h8000, 1'b1);
    send_beat(LRS_OP_LOAD, 9'd511, 16'hFFFF, 1'b1);
    send_beat(LRS_OP_LOAD, 9'd257, 16'h0000, 1'b0);
    send_beat(LRS_OP_LOAD, 9'd0, 16'h0000, 1'b0);
    send_beat(LRS_OP_FEATURE, 9'd0, 16'h1000, 1'b0);
    send_beat(LRS_OP_LOAD, 9'd0, 16'h7FFF, 1'b0);
    send_beat(LRS_OP_LOAD, 9'd2, 16'hF000, 1'b0);
    send_beat(LRS_OP_FEATURE, 9'd0, 16'h1000, 1'b1);
    send_beat(LRS_OP_FEATURE, 9'h1FF, 16'hFFFF, 1'b1);

    // full store plus one past it, every label set
    set_threshold(16'd0);
    score_vector(LRS_MAX_FEATURES + 1, 0);

    set_threshold(16'hFFFF);
    random_segment(70);
    set_threshold(16'($urandom));
    steady = 1'b1;
    random_segment(70);
    steady = 1'b0;
    set_threshold(16'd1);
    random_segment(70);
    set_threshold(16'($urandom_range(30000, 36000)));
    random_segment(70);
    set_threshold(16'($urandom));
    random_segment(70);

    // drain
    in_tvalid <= 1'b0;
    while (results_pending != 0) begin
      @(negedge clk);
    end
    repeat (12) @(negedge clk);
    if (error_count == 0 && results_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lrs_pkg.sv
hw/rtl/lrs_ram.sv
hw/rtl/lrs_sigmoid_rom.sv
hw/rtl/logistic_regression_scorer_unit.sv
verif/lrs_score_checker.sv
verif/tb_top.sv
